[design/matrix_compose_vertex_transform_assert.svh]
// matrix_compose_vertex_transform_assert.svh
// Assertion macros used by the vertex transform top module; no dependencies.
`ifndef MATRIX_COMPOSE_VERTEX_TRANSFORM_ASSERT_SVH
`define MATRIX_COMPOSE_VERTEX_TRANSFORM_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define MCVT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mcvt: assertion failed");
// expression must never be true outside reset
`define MCVT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("mcvt: forbidden condition");
`else
`define MCVT_ASSERT(lbl, clk, rst, prop)
`define MCVT_NEVER(lbl, clk, rst, expr)
`endif
`endif

[design/mcvt_pkg.sv]
`timescale 1ns / 1ps
// mcvt_pkg: payload types, command codes and the sine table builder
// for the vertex transform block. No dependencies.
package mcvt_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int WORD_W        = 32;
   localparam int ANGLE_W       = 16;
   localparam int CMD_W         = 3;

   localparam int ANGLE_STEPS         = 360;
   localparam int QUARTER_STEPS       = 90;
   localparam int HALF_STEPS          = 180;
   localparam int THREE_QUARTER_STEPS = 270;
   localparam int TABLE_DEPTH         = QUARTER_STEPS + 1;

   // angle / 360 as a multiply by a reciprocal; result is exact or one low
   localparam int RECIP_SHIFT = 24;
   localparam int ANGLE_RECIP = (1 << RECIP_SHIFT) / ANGLE_STEPS;

   // pi/180 in Q2.30 and the Taylor divisors (2n)(2n+1)
   localparam longint unsigned DEG_TO_RAD_Q30 = 64'd18740330;
   localparam int TAYLOR_TERMS = 8;
   localparam longint unsigned TaylorDiv [TAYLOR_TERMS] =
      '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272};

   typedef enum logic [CMD_W-1:0] {
      CMD_IDENTITY  = 3'd0,
      CMD_ROT_X     = 3'd1,
      CMD_ROT_Y     = 3'd2,
      CMD_ROT_Z     = 3'd3,
      CMD_TRANSLATE = 3'd4,
      CMD_POINT     = 3'd5
   } cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0]          cmd;
      logic [ANGLE_W-1:0]        angle_deg;
      logic signed [WORD_W-1:0]  pos_x;
      logic signed [WORD_W-1:0]  pos_y;
      logic signed [WORD_W-1:0]  pos_z;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0]  out_x;
      logic signed [WORD_W-1:0]  out_y;
      logic signed [WORD_W-1:0]  out_z;
      logic signed [WORD_W-1:0]  out_w;
   } rsp_type;

   // row-major: [row][col]
   typedef logic [3:0][3:0][WORD_W-1:0] mat_type;

   // control handed to the product stage
   typedef struct packed {
      logic    load;
      cmd_type cmd;
   } prod_ctl_type;

   typedef logic [WORD_W-1:0] sin_table_type [TABLE_DEPTH];

   // sin(0..90 deg): Q30 Taylor series, rounded half up to frac_bits
   function automatic sin_table_type build_sin_table(input int frac_bits);
      sin_table_type     tbl;
      longint unsigned   x;
      longint unsigned   t;
      longint            sum;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         x   = 64'(k) * DEG_TO_RAD_Q30;
         t   = x;
         sum = longint'(x);
         for (int n = 1; n <= TAYLOR_TERMS; n++) begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / TaylorDiv[n-1];
            if ((n & 1) != 0)
               sum = sum - longint'(t);
            else
               sum = sum + longint'(t);
         end
         if (sum < 0)
            sum = 0;
         tbl[k] = WORD_W'((64'(sum) + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits));
      end
      return tbl;
   endfunction

endpackage

[design/matrix_compose_vertex_transform.sv]
`timescale 1ns / 1ps
// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid / req_ready | mcvt_pkg::req_type (cmd, angle, x, y, z)
// rsp     | out       | rsp_valid / rsp_ready | mcvt_pkg::rsp_type (x, y, z, w)
// Point requests stream at one per cycle unless rsp_ready stalls the output; each result passes
// the input, product and result registers. A matrix command (identity, rotate, translate)
// holds off the next request while in the input stage, letting it in as the matrix is written.
// Pipeline: trig lookup into input register, 16 parallel multipliers into product
// register, row sums with saturation into matrix or result register.
// Reset loads the identity matrix and empties the pipeline; a stalled result only
// holds the stages behind it that need the output register.
// Depends on mcvt_pkg, mcvt_trig, mcvt_prod, mcvt_row_sum.
`include "matrix_compose_vertex_transform_assert.svh"
module matrix_compose_vertex_transform #(
   parameter int FRAC_BITS = mcvt_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mcvt_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mcvt_pkg::rsp_type rsp_payload
);

   localparam int WORD_W = mcvt_pkg::WORD_W;
   localparam int TRIG_W = FRAC_BITS + 2;
   localparam int PROD_W = 2 * WORD_W - FRAC_BITS;

   function automatic mcvt_pkg::mat_type identity_of();
      mcvt_pkg::mat_type m;
      m = '0;
      for (int r = 0; r < 4; r++) begin
         m[r][r] = WORD_W'(64'd1 << FRAC_BITS);
      end
      return m;
   endfunction

   localparam mcvt_pkg::mat_type IDENTITY = identity_of();

   logic                       accept;
   logic                       cmd_ok;
   logic signed [TRIG_W-1:0]   sin_val;
   logic signed [TRIG_W-1:0]   cos_val;

   // input stage
   logic                       s0_valid_ff, s0_valid_in;
   mcvt_pkg::cmd_type          s0_cmd_ff;
   logic signed [WORD_W-1:0]   s0_pos_x_ff, s0_pos_y_ff, s0_pos_z_ff;
   logic signed [TRIG_W-1:0]   s0_sin_ff, s0_cos_ff;

   // product stage
   logic                       s1_valid_ff, s1_valid_in;
   mcvt_pkg::cmd_type          s1_cmd_ff;
   logic [3:0][3:0][PROD_W-1:0] prod_ff;
   mcvt_pkg::prod_ctl_type     prod_ctl;

   logic signed [WORD_W-1:0]   pair_lo [4];
   logic signed [WORD_W-1:0]   pair_hi [4];
   logic signed [WORD_W-1:0]   total [4];

   mcvt_pkg::mat_type          matrix_ff, matrix_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   mcvt_pkg::rsp_type          rsp_payload_ff, rsp_payload_in;

   logic out_free, s1_go, s1_free, s0_go, s0_free, s0_upd, s1_point;

   assign s1_point  = (s1_cmd_ff == mcvt_pkg::CMD_POINT);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   // matrix updates retire without the output register
   assign s1_go     = s1_valid_ff && (!s1_point || out_free);
   assign s1_free   = !s1_valid_ff || s1_go;
   assign s0_go     = s0_valid_ff && s1_free;
   assign s0_free   = !s0_valid_ff || s0_go;
   // an update in the input stage must reach the matrix before anything reads it
   assign s0_upd    = s0_valid_ff && (s0_cmd_ff != mcvt_pkg::CMD_POINT);
   assign req_ready = s0_free && !s0_upd;
   assign accept    = req_valid && req_ready;

   always_comb begin
      case (mcvt_pkg::cmd_type'(req_payload.cmd))
         mcvt_pkg::CMD_IDENTITY,
         mcvt_pkg::CMD_ROT_X,
         mcvt_pkg::CMD_ROT_Y,
         mcvt_pkg::CMD_ROT_Z,
         mcvt_pkg::CMD_TRANSLATE,
         mcvt_pkg::CMD_POINT: cmd_ok = 1'b1;
         default:             cmd_ok = 1'b0;
      endcase
   end

   mcvt_trig #(.FRAC_BITS(FRAC_BITS)) u_trig (
      .angle_deg (req_payload.angle_deg),
      .sin_val   (sin_val),
      .cos_val   (cos_val)
   );

   // unused command codes are taken and dropped here
   always_comb begin
      s0_valid_in = s0_valid_ff && !s0_go;
      if (accept) begin
         s0_valid_in = cmd_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s0_cmd_ff   <= mcvt_pkg::cmd_type'(req_payload.cmd);
         s0_pos_x_ff <= req_payload.pos_x;
         s0_pos_y_ff <= req_payload.pos_y;
         s0_pos_z_ff <= req_payload.pos_z;
         s0_sin_ff   <= sin_val;
         s0_cos_ff   <= cos_val;
      end
   end

   assign prod_ctl.load = s0_go;
   assign prod_ctl.cmd  = s0_cmd_ff;

   mcvt_prod #(.FRAC_BITS(FRAC_BITS)) u_prod (
      .clock   (clock),
      .ctl     (prod_ctl),
      .matrix  (matrix_ff),
      .pos_x   (s0_pos_x_ff),
      .pos_y   (s0_pos_y_ff),
      .pos_z   (s0_pos_z_ff),
      .sin_val (s0_sin_ff),
      .cos_val (s0_cos_ff),
      .prod_ff (prod_ff)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff && !s1_go;
      if (s0_go) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_go) begin
         s1_cmd_ff <= s0_cmd_ff;
      end
   end

   for (genvar r = 0; r < 4; r++) begin : g_row
      mcvt_row_sum #(.FRAC_BITS(FRAC_BITS)) u_sum (
         .prod    (prod_ff[r]),
         .pair_lo (pair_lo[r]),
         .pair_hi (pair_hi[r]),
         .total   (total[r])
      );
   end

   // post-multiply: only the columns the operation touches change; identity replaces the whole matrix
   always_comb begin
      matrix_in = matrix_ff;
      if (s1_valid_ff) begin
         case (s1_cmd_ff)
            mcvt_pkg::CMD_IDENTITY: begin
               matrix_in = IDENTITY;
            end
            mcvt_pkg::CMD_ROT_X: begin
               for (int r = 0; r < 4; r++) begin
                  matrix_in[r][1] = pair_lo[r];
                  matrix_in[r][2] = pair_hi[r];
               end
            end
            mcvt_pkg::CMD_ROT_Y: begin
               for (int r = 0; r < 4; r++) begin
                  matrix_in[r][0] = pair_lo[r];
                  matrix_in[r][2] = pair_hi[r];
               end
            end
            mcvt_pkg::CMD_ROT_Z: begin
               for (int r = 0; r < 4; r++) begin
                  matrix_in[r][0] = pair_lo[r];
                  matrix_in[r][1] = pair_hi[r];
               end
            end
            mcvt_pkg::CMD_TRANSLATE: begin
               for (int r = 0; r < 4; r++) begin
                  matrix_in[r][3] = total[r];
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff <= IDENTITY;
      end else begin
         matrix_ff <= matrix_in;
      end
   end

   always_comb begin
      rsp_valid_in         = rsp_valid_ff;
      rsp_payload_in       = rsp_payload_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff && s1_point;
      end
      rsp_payload_in.out_x = total[0];
      rsp_payload_in.out_y = total[1];
      rsp_payload_in.out_z = total[2];
      rsp_payload_in.out_w = total[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff && s1_point) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // no request may sit in the input stage behind an uncommitted update
   `MCVT_NEVER(a_update_hazard, clock, reset, s1_valid_ff && !s1_point && s0_valid_ff)
   // a result appears only when a point request leaves the product stage
   `MCVT_ASSERT(a_rsp_from_point, clock, reset, $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_point))
   // the matrix moves only when an update retires
   `MCVT_ASSERT(a_matrix_hold, clock, reset, !(s1_valid_ff && !s1_point) |=> $stable(matrix_ff))

endmodule

[design/mcvt_trig.sv]
`timescale 1ns / 1ps
// mcvt_trig: angle reduction mod 360 and sine/cosine lookup by quadrant.
// Depends on mcvt_pkg.
module mcvt_trig #(
   parameter int FRAC_BITS = mcvt_pkg::FRAC_BITS_DEF
) (
   input  logic [mcvt_pkg::ANGLE_W-1:0] angle_deg,
   output logic signed [FRAC_BITS+1:0]  sin_val,
   output logic signed [FRAC_BITS+1:0]  cos_val
);

   localparam int TRIG_W = FRAC_BITS + 2;
   localparam int QUOT_W = 8;
   localparam int REM_W  = 10;
   localparam int DEG_W  = 9;
   localparam int IDX_W  = 7;
   localparam mcvt_pkg::sin_table_type SIN_TABLE = mcvt_pkg::build_sin_table(FRAC_BITS);

   logic [2*mcvt_pkg::ANGLE_W-1:0] quot_prod;
   logic [QUOT_W-1:0]              quot;
   logic [REM_W-1:0]               rem_raw;
   logic [REM_W-1:0]               cos_raw;
   logic [DEG_W-1:0]               sin_angle;
   logic [DEG_W-1:0]               cos_angle;

   function automatic logic signed [TRIG_W-1:0] sin_lookup(input logic [DEG_W-1:0] a);
      logic [IDX_W-1:0]         idx;
      logic                     neg;
      logic signed [TRIG_W-1:0] mag;
      if (a <= DEG_W'(mcvt_pkg::QUARTER_STEPS)) begin
         idx = IDX_W'(a);
         neg = 1'b0;
      end else if (a <= DEG_W'(mcvt_pkg::HALF_STEPS)) begin
         idx = IDX_W'(DEG_W'(mcvt_pkg::HALF_STEPS) - a);
         neg = 1'b0;
      end else if (a <= DEG_W'(mcvt_pkg::THREE_QUARTER_STEPS)) begin
         idx = IDX_W'(a - DEG_W'(mcvt_pkg::HALF_STEPS));
         neg = 1'b1;
      end else begin
         idx = IDX_W'(DEG_W'(mcvt_pkg::ANGLE_STEPS) - a);
         neg = 1'b1;
      end
      mag = $signed(SIN_TABLE[idx][TRIG_W-1:0]);
      return neg ? -mag : mag;
   endfunction

   assign quot_prod = (2*mcvt_pkg::ANGLE_W)'(angle_deg)
                    * (2*mcvt_pkg::ANGLE_W)'(mcvt_pkg::ANGLE_RECIP);
   assign quot      = quot_prod[mcvt_pkg::RECIP_SHIFT +: QUOT_W];
   // remainder lands in [0, 720): one conditional subtract finishes it
   assign rem_raw   = REM_W'(angle_deg - mcvt_pkg::ANGLE_W'(quot)
                                       * mcvt_pkg::ANGLE_W'(mcvt_pkg::ANGLE_STEPS));
   assign sin_angle = (rem_raw >= REM_W'(mcvt_pkg::ANGLE_STEPS))
                    ? DEG_W'(rem_raw - REM_W'(mcvt_pkg::ANGLE_STEPS)) : DEG_W'(rem_raw);
   assign cos_raw   = REM_W'(sin_angle) + REM_W'(mcvt_pkg::QUARTER_STEPS);
   assign cos_angle = (cos_raw >= REM_W'(mcvt_pkg::ANGLE_STEPS))
                    ? DEG_W'(cos_raw - REM_W'(mcvt_pkg::ANGLE_STEPS)) : DEG_W'(cos_raw);

   assign sin_val = sin_lookup(sin_angle);
   assign cos_val = sin_lookup(cos_angle);

endmodule

[design/mcvt_prod.sv]
`timescale 1ns / 1ps
// mcvt_prod: operand selection and the 4x4 array of Q-format multipliers,
// registered. Depends on mcvt_pkg.
module mcvt_prod #(
   parameter int FRAC_BITS = mcvt_pkg::FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  mcvt_pkg::prod_ctl_type                 ctl,
   input  mcvt_pkg::mat_type                      matrix,
   input  logic signed [mcvt_pkg::WORD_W-1:0]     pos_x,
   input  logic signed [mcvt_pkg::WORD_W-1:0]     pos_y,
   input  logic signed [mcvt_pkg::WORD_W-1:0]     pos_z,
   input  logic signed [FRAC_BITS+1:0]            sin_val,
   input  logic signed [FRAC_BITS+1:0]            cos_val,
   output logic [3:0][3:0][2*mcvt_pkg::WORD_W-FRAC_BITS-1:0] prod_ff
);

   localparam int WORD_W = mcvt_pkg::WORD_W;
   localparam int FULL_W = 2 * WORD_W;
   localparam int PROD_W = FULL_W - FRAC_BITS;

   logic signed [WORD_W-1:0] sin_ext;
   logic signed [WORD_W-1:0] nsin_ext;
   logic signed [WORD_W-1:0] cos_ext;
   logic signed [WORD_W-1:0] one_val;
   logic signed [WORD_W-1:0] opa [4][4];
   logic signed [WORD_W-1:0] opb [4];
   logic signed [FULL_W-1:0] full_prod [4][4];
   logic [3:0][3:0][PROD_W-1:0] prod_in;

   assign sin_ext  = WORD_W'(sin_val);
   assign nsin_ext = -sin_ext;
   assign cos_ext  = WORD_W'(cos_val);
   assign one_val  = $signed(WORD_W'(64'd1 << FRAC_BITS));

   // Lanes per row: rotations give (mi*c, mj*s', mi*-s', mj*c) -> two new columns;
   // point and translate give a full row dot (x, y, z, 1).
   always_comb begin
      opb = '{pos_x, pos_y, pos_z, one_val};
      for (int r = 0; r < 4; r++) begin
         opa[r] = '{$signed(matrix[r][0]), $signed(matrix[r][1]),
                    $signed(matrix[r][2]), $signed(matrix[r][3])};
      end
      case (ctl.cmd)
         mcvt_pkg::CMD_ROT_X: begin
            opb = '{cos_ext, sin_ext, nsin_ext, cos_ext};
            for (int r = 0; r < 4; r++) begin
               opa[r] = '{$signed(matrix[r][1]), $signed(matrix[r][2]),
                          $signed(matrix[r][1]), $signed(matrix[r][2])};
            end
         end
         mcvt_pkg::CMD_ROT_Y: begin
            opb = '{cos_ext, nsin_ext, sin_ext, cos_ext};
            for (int r = 0; r < 4; r++) begin
               opa[r] = '{$signed(matrix[r][0]), $signed(matrix[r][2]),
                          $signed(matrix[r][0]), $signed(matrix[r][2])};
            end
         end
         mcvt_pkg::CMD_ROT_Z: begin
            opb = '{cos_ext, sin_ext, nsin_ext, cos_ext};
            for (int r = 0; r < 4; r++) begin
               opa[r] = '{$signed(matrix[r][0]), $signed(matrix[r][1]),
                          $signed(matrix[r][0]), $signed(matrix[r][1])};
            end
         end
         default: begin
         end
      endcase
   end

   // arithmetic shift = floor, matching truncation of the fixed-point product
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int l = 0; l < 4; l++) begin
            full_prod[r][l] = opa[r][l] * opb[l];
            prod_in[r][l]   = PROD_W'(full_prod[r][l] >>> FRAC_BITS);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         prod_ff <= prod_in;
      end
   end

endmodule

[design/mcvt_row_sum.sv]
`timescale 1ns / 1ps
// mcvt_row_sum: pair sums and full sum of one row of products, saturated
// to 32 bits. Depends on mcvt_pkg.
module mcvt_row_sum #(
   parameter int FRAC_BITS = mcvt_pkg::FRAC_BITS_DEF
) (
   input  logic [3:0][2*mcvt_pkg::WORD_W-FRAC_BITS-1:0] prod,
   output logic signed [mcvt_pkg::WORD_W-1:0]           pair_lo,
   output logic signed [mcvt_pkg::WORD_W-1:0]           pair_hi,
   output logic signed [mcvt_pkg::WORD_W-1:0]           total
);

   localparam int WORD_W = mcvt_pkg::WORD_W;
   localparam int PROD_W = 2 * WORD_W - FRAC_BITS;
   localparam int SUM_W  = PROD_W + 2;

   logic signed [SUM_W-1:0] lo_sum;
   logic signed [SUM_W-1:0] hi_sum;
   logic signed [SUM_W-1:0] all_sum;

   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-WORD_W:0] top_bits;
      top_bits = v[SUM_W-1:WORD_W-1];
      if (top_bits == '0 || top_bits == '1)
         return $signed(v[WORD_W-1:0]);
      else if (v[SUM_W-1])
         return $signed({1'b1, {(WORD_W-1){1'b0}}});
      else
         return $signed({1'b0, {(WORD_W-1){1'b1}}});
   endfunction

   assign lo_sum  = SUM_W'($signed(prod[0])) + SUM_W'($signed(prod[1]));
   assign hi_sum  = SUM_W'($signed(prod[2])) + SUM_W'($signed(prod[3]));
   assign all_sum = lo_sum + hi_sum;

   assign pair_lo = sat_word(lo_sum);
   assign pair_hi = sat_word(hi_sum);
   assign total   = sat_word(all_sum);

endmodule
